FILE: hw/rtl/owbm_pkg.sv
package owbm_pkg;

	// Timer width default
	localparam int TIMER_BITS_DEF = 10;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_WAIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TIME    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_REC     = 3'd7;

	// Register reset values
	localparam logic [9:0] RST_RESET_LOW    = 10'd750;
	localparam logic [7:0] RST_RESET_REC    = 8'd15;
	localparam logic [9:0] RST_PRES_WAIT    = 10'd200;
	localparam logic [9:0] RST_REL_WAIT     = 10'd240;
	localparam logic [7:0] RST_SLOT_TIME    = 8'd60;
	localparam logic [3:0] RST_SHORT_LOW    = 4'd2;
	localparam logic [5:0] RST_SAMPLE_DELAY = 6'd12;
	localparam logic [7:0] RST_READ_REC     = 8'd50;

	// Command codes
	localparam int ACTION_W = 2;
	localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

	// Status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PRESENCE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_RELEASE = 2'd2;

	// Sequencer phases
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_REC = 4'd2;
	localparam logic [PHASE_W-1:0] PH_PRES    = 4'd3;
	localparam logic [PHASE_W-1:0] PH_REL     = 4'd4;
	localparam logic [PHASE_W-1:0] PH_W_LOW   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_W_HIGH  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_R_LOW   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_R_WAIT  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_R_REC   = 4'd9;

	localparam int BYTE_W = 8;
	localparam int BITCNT_W = 4;
	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [7:0] reset_recovery_time;
		logic [9:0] presence_wait_limit;
		logic [9:0] release_wait_limit;
		logic [7:0] slot_time;
		logic [3:0] short_low_time;
		logic [5:0] sample_delay;
		logic [7:0] read_recovery_time;
	} cfg_t;

	typedef struct packed {
		logic                drive_low;
		logic                busy_res;
		logic                done_res;
		logic [BYTE_W-1:0]   read_data;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

FILE: hw/rtl/owbm_cmd_if.sv
interface owbm_cmd_if
	import owbm_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                bus_level;
	logic [BYTE_W-1:0]   write_byte;

	modport source (output valid, output action, output bus_level, output write_byte,
		input ready);
	modport sink (input valid, input action, input bus_level, input write_byte,
		output ready);
endinterface

FILE: hw/rtl/owbm_res_if.sv
interface owbm_res_if
	import owbm_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                drive_low;
	logic                busy_res;
	logic                done_res;
	logic [BYTE_W-1:0]   read_data;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output read_data, output status, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input read_data, input status, output ready);
endinterface

FILE: hw/rtl/owbm_cfg.sv
module owbm_cfg
	import owbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time      <= RST_RESET_LOW;
			cfg_q.reset_recovery_time <= RST_RESET_REC;
			cfg_q.presence_wait_limit <= RST_PRES_WAIT;
			cfg_q.release_wait_limit  <= RST_REL_WAIT;
			cfg_q.slot_time           <= RST_SLOT_TIME;
			cfg_q.short_low_time      <= RST_SHORT_LOW;
			cfg_q.sample_delay        <= RST_SAMPLE_DELAY;
			cfg_q.read_recovery_time  <= RST_READ_REC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESET_LOW:    cfg_q.reset_low_time      <= cfg_data[9:0];
				CFG_RESET_REC:    cfg_q.reset_recovery_time <= cfg_data[7:0];
				CFG_PRES_WAIT:    cfg_q.presence_wait_limit <= cfg_data[9:0];
				CFG_REL_WAIT:     cfg_q.release_wait_limit  <= cfg_data[9:0];
				CFG_SLOT_TIME:    cfg_q.slot_time           <= cfg_data[7:0];
				CFG_SHORT_LOW:    cfg_q.short_low_time      <= cfg_data[3:0];
				CFG_SAMPLE_DELAY: cfg_q.sample_delay        <= cfg_data[5:0];
				CFG_READ_REC:     cfg_q.read_recovery_time  <= cfg_data[7:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/owbm_seq.sv
module owbm_seq
	import owbm_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                adv,
	input  logic [ACTION_W-1:0] action,
	input  logic                bus_level,
	input  logic [BYTE_W-1:0]   write_byte,
	output res_t                res
);

	localparam int CMP_W = (TIMER_BITS > 10) ? TIMER_BITS : 10;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	logic [PHASE_W-1:0]    phase_q,  phase_d;
	logic [TIMER_BITS-1:0] timer_q,  timer_d;
	logic [BITCNT_W-1:0]   bitcnt_q, bitcnt_d;
	logic [BYTE_W-1:0]     shift_q,  shift_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic [BYTE_W-1:0]     rdhold_q, rdhold_d;

	// One tick of the sequencer
	always_comb begin
		logic [PHASE_W-1:0]    ph;
		logic [TIMER_BITS-1:0] tcnt;
		logic [CMP_W-1:0]      dur;
		logic                  hit;
		logic                  done;
		logic                  drive;
		logic [BITCNT_W-1:0]   bc_inc;

		ph       = phase_q;
		timer_d  = timer_q;
		bitcnt_d = bitcnt_q;
		shift_d  = shift_q;
		status_d = status_q;
		rdhold_d = rdhold_q;
		done     = 1'b0;
		drive    = 1'b0;

		// command start, the same tick is the first tick of the first phase
		if (ph == PH_IDLE && action != ACT_NONE) begin
			timer_d  = '0;
			bitcnt_d = '0;
			unique case (action)
				ACT_RESET: ph = PH_RST_LOW;
				ACT_WRITE: begin
					shift_d = write_byte;
					ph      = PH_W_LOW;
				end
				ACT_READ: begin
					shift_d = '0;
					ph      = PH_R_LOW;
				end
				default: ph = PH_IDLE;
			endcase
		end

		// duration or limit for the current phase
		unique case (ph)
			PH_RST_LOW: dur = CMP_W'(cfg.reset_low_time);
			PH_RST_REC: dur = CMP_W'(cfg.reset_recovery_time);
			PH_PRES:    dur = bus_level ? CMP_W'(cfg.presence_wait_limit)
				: CMP_W'(cfg.release_wait_limit);
			PH_REL:     dur = CMP_W'(cfg.release_wait_limit);
			PH_W_LOW:   dur = shift_d[0] ? CMP_W'(cfg.short_low_time) : CMP_W'(cfg.slot_time);
			PH_W_HIGH:  dur = shift_d[0] ? CMP_W'(cfg.slot_time) : CMP_W'(cfg.short_low_time);
			PH_R_LOW:   dur = CMP_W'(cfg.short_low_time);
			PH_R_WAIT:  dur = CMP_W'(cfg.sample_delay);
			PH_R_REC:   dur = CMP_W'(cfg.read_recovery_time);
			default:    dur = '0;
		endcase

		// first low tick of the presence watch restarts the count at one
		tcnt = (ph == PH_PRES && !bus_level) ? TIMER_BITS'(1)
			: timer_d + TIMER_BITS'(1);
		hit    = (CMP_W'(tcnt) >= dur) || (tcnt == TMAX);
		bc_inc = bitcnt_d + BITCNT_W'(1);

		unique case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				drive   = 1'b1;
				timer_d = hit ? '0 : tcnt;
				if (hit) ph = PH_RST_REC;
			end
			PH_RST_REC: begin
				timer_d = hit ? '0 : tcnt;
				if (hit) ph = PH_PRES;
			end
			PH_PRES: begin
				if (!bus_level) begin
					ph = PH_REL;
				end
				if (hit) begin
					done     = 1'b1;
					status_d = bus_level ? ST_NO_PRESENCE : ST_NOT_RELEASE;
				end else begin
					timer_d = tcnt;
				end
			end
			PH_REL: begin
				if (bus_level) begin
					done     = 1'b1;
					status_d = ST_OK;
				end else if (hit) begin
					done     = 1'b1;
					status_d = ST_NOT_RELEASE;
				end else begin
					timer_d = tcnt;
				end
			end
			PH_W_LOW: begin
				drive   = 1'b1;
				timer_d = hit ? '0 : tcnt;
				if (hit) ph = PH_W_HIGH;
			end
			PH_W_HIGH: begin
				timer_d = hit ? '0 : tcnt;
				if (hit) begin
					shift_d  = shift_d >> 1;
					bitcnt_d = bc_inc;
					if (bc_inc >= BITS_PER_BYTE) begin
						done     = 1'b1;
						status_d = ST_OK;
					end else begin
						ph = PH_W_LOW;
					end
				end
			end
			PH_R_LOW: begin
				drive   = 1'b1;
				timer_d = hit ? '0 : tcnt;
				if (hit) ph = PH_R_WAIT;
			end
			PH_R_WAIT: begin
				timer_d = hit ? '0 : tcnt;
				if (hit) begin
					shift_d = {bus_level, shift_d[BYTE_W-1:1]};
					ph      = PH_R_REC;
				end
			end
			PH_R_REC: begin
				timer_d = hit ? '0 : tcnt;
				if (hit) begin
					bitcnt_d = bc_inc;
					if (bc_inc >= BITS_PER_BYTE) begin
						rdhold_d = shift_d;
						done     = 1'b1;
						status_d = ST_OK;
					end else begin
						ph = PH_R_LOW;
					end
				end
			end
			default: begin
				ph       = PH_IDLE;
				timer_d  = '0;
				bitcnt_d = '0;
			end
		endcase

		// command end
		if (done) begin
			ph       = PH_IDLE;
			timer_d  = '0;
			bitcnt_d = '0;
		end

		phase_d       = ph;
		res.drive_low = drive;
		res.busy_res  = (ph != PH_IDLE);
		res.done_res  = done;
		res.read_data = rdhold_d;
		res.status    = status_d;
	end

	// State advances once per tick taken by the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			bitcnt_q <= '0;
			shift_q  <= '0;
			status_q <= ST_OK;
			rdhold_q <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			bitcnt_q <= bitcnt_d;
			shift_q  <= shift_d;
			status_q <= status_d;
			rdhold_q <= rdhold_d;
		end
	end

endmodule

FILE: hw/rtl/one_wire_bus_master.sv
// Channel  Role    Item fields
// cmd      sink    action, bus_level, write_byte (one microsecond tick)
// res      source  drive_low, busy_res, done_res, read_data, status
// cfg      write   cfg_we, cfg_index, cfg_data (no read-back)
//
// One tick item per clock cycle sustained while res is ready; a tick taken from cmd
// sits in the input register and is presented on res from the result register.
// The sequencer state steps once for each tick moved into the result register.
// arst_n clears the pipeline valids, the sequencer and the configuration registers to
// their reset values. A stall on res holds the result register and backs up into
// the input register; cmd.ready drops only when both are full.
module one_wire_bus_master
	import owbm_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	owbm_cmd_if.sink              cmd,
	owbm_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                cfg;
	res_t                res_next;
	res_t                res_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic [ACTION_W-1:0] action_s1;
	logic                level_s1;
	logic [BYTE_W-1:0]   wbyte_s1;
	logic                adv;

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	owbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owbm_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adv        (adv),
		.action     (action_s1),
		.bus_level  (level_s1),
		.write_byte (wbyte_s1),
		.res        (res_next)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			level_s1  <= cmd.bus_level;
			wbyte_s1  <= cmd.write_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid     = valid_s2;
	assign res.drive_low = res_s2.drive_low;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.read_data = res_s2.read_data;
	assign res.status    = res_s2.status;

	// A finished command is never still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.done_res && res.busy_res))
		else $error("done and busy on the same item");

	// The line is only driven inside a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.drive_low |-> res.busy_res)
		else $error("line driven while idle");

	// A tick leaving the input register lands in the result register
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("tick lost between stages");

	// Status only reports defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == ST_OK || res.status == ST_NO_PRESENCE
			|| res.status == ST_NOT_RELEASE))
		else $error("undefined status code");

endmodule
